FILE: src/frac_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frac_pkg
// Shared widths, command and status types for the fraction reducer.
// ----------------------------------------------------------------------------
package frac_pkg;

	localparam int DATA_WIDTH = 32;
	localparam int DIV_WIDTH  = DATA_WIDTH - 1;
	localparam int CNT_WIDTH  = $clog2(DATA_WIDTH);
	localparam int S_TDATA_WIDTH = ((2 * DATA_WIDTH + 7) / 8) * 8;
	localparam int M_TDATA_WIDTH = ((2 * DATA_WIDTH + DIV_WIDTH + 7) / 8) * 8;
	localparam int M_PAD_WIDTH   = M_TDATA_WIDTH - (2 * DATA_WIDTH + DIV_WIDTH);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_GCD   = 5'b00010,
		ST_SHIFT = 5'b00100,
		ST_DIV   = 5'b01000,
		ST_DONE  = 5'b10000
	} state_t;

	typedef struct packed {
		logic load;
		logic gcd_step;
		logic gcd_fold;
		logic shl_step;
		logic div_init;
		logic div_step;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic zero_den;
		logic gcd_done;
		logic shl_done;
		logic div_last;
	} sts_t;

endpackage

FILE: src/frac_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frac_ctrl
// Sequencer: steps the datapath through gcd, shift-back, division and output.
// ----------------------------------------------------------------------------
module frac_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	output logic           m_tvalid,
	input  logic           m_tready,
	input  frac_pkg::sts_t sts,
	output frac_pkg::cmd_t cmd
);

	frac_pkg::state_t state_q;
	frac_pkg::state_t state_d;
	logic             out_valid_q;
	logic             out_free;

	assign out_free = !out_valid_q || m_tready;
	assign s_tready = (state_q == frac_pkg::ST_IDLE);
	assign m_tvalid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			frac_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = frac_pkg::ST_GCD;
				end
			end
			frac_pkg::ST_GCD: begin
				if (sts.zero_den) begin
					state_d = frac_pkg::ST_DONE;
				end else if (sts.gcd_done) begin
					cmd.gcd_fold = 1'b1;
					state_d      = frac_pkg::ST_SHIFT;
				end else begin
					cmd.gcd_step = 1'b1;
				end
			end
			frac_pkg::ST_SHIFT: begin
				if (sts.shl_done) begin
					cmd.div_init = 1'b1;
					state_d      = frac_pkg::ST_DIV;
				end else begin
					cmd.shl_step = 1'b1;
				end
			end
			frac_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = frac_pkg::ST_DONE;
				end
			end
			frac_pkg::ST_DONE: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = frac_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = frac_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= frac_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: src/frac_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frac_dp
// Datapath: magnitudes, binary gcd, shift-back and two restoring dividers.
// ----------------------------------------------------------------------------
module frac_dp (
	input  logic                                  clk,
	input  frac_pkg::cmd_t                        cmd,
	output frac_pkg::sts_t                        sts,
	input  logic signed [frac_pkg::DATA_WIDTH-1:0] numerator,
	input  logic signed [frac_pkg::DATA_WIDTH-1:0] denominator,
	output logic signed [frac_pkg::DATA_WIDTH-1:0] reduced_numerator,
	output logic signed [frac_pkg::DATA_WIDTH-1:0] reduced_denominator,
	output logic        [frac_pkg::DIV_WIDTH-1:0]  divisor,
	output logic                                  zero_denominator
);

	localparam int W = frac_pkg::DATA_WIDTH;

	logic                                nneg_q, dneg_q, err_q;
	logic [W-1:0]                        nmag_q, dmag_q;
	logic [W-1:0]                        a_q, b_q;
	logic [frac_pkg::CNT_WIDTH-1:0]      k_q;
	logic [frac_pkg::CNT_WIDTH-1:0]      cnt_q;
	logic [W-1:0]                        qn_q, qd_q, rn_q, rd_q;
	logic [W-1:0]                        nmag_in, dmag_in;
	logic [W-1:0]                        diff_ab, diff_ba;
	logic [W:0]                          rn_sh, rd_sh, g_ext;
	logic [W:0]                          rn_sub, rd_sub;
	logic                                n_ge, d_ge;
	logic [W-1:0]                        out_n, out_d;

	assign nmag_in = numerator[W-1]   ? (~numerator + 1'b1)   : numerator;
	assign dmag_in = denominator[W-1] ? (~denominator + 1'b1) : denominator;
	assign diff_ab = a_q - b_q;
	assign diff_ba = b_q - a_q;

	// one quotient bit per cycle on each lane, shared divisor in a_q
	assign g_ext  = {1'b0, a_q};
	assign rn_sh  = {rn_q, qn_q[W-1]};
	assign rd_sh  = {rd_q, qd_q[W-1]};
	assign rn_sub = rn_sh - g_ext;
	assign rd_sub = rd_sh - g_ext;
	assign n_ge   = (rn_sh >= g_ext);
	assign d_ge   = (rd_sh >= g_ext);

	assign sts.zero_den = err_q;
	assign sts.gcd_done = (a_q == '0) || (b_q == '0);
	assign sts.shl_done = (k_q == '0);
	assign sts.div_last = (cnt_q == '0);

	assign out_n = err_q ? nmag_q : qn_q;
	assign out_d = err_q ? dmag_q : qd_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			nneg_q <= numerator[W-1];
			dneg_q <= denominator[W-1];
			nmag_q <= nmag_in;
			dmag_q <= dmag_in;
			err_q  <= (dmag_in == '0);
			a_q    <= nmag_in;
			b_q    <= dmag_in;
			k_q    <= '0;
		end
		if (cmd.gcd_step) begin
			if (!a_q[0] && !b_q[0]) begin
				a_q <= a_q >> 1;
				b_q <= b_q >> 1;
				k_q <= k_q + 1'b1;
			end else if (!a_q[0]) begin
				a_q <= a_q >> 1;
			end else if (!b_q[0]) begin
				b_q <= b_q >> 1;
			end else if (a_q >= b_q) begin
				a_q <= diff_ab >> 1;
			end else begin
				b_q <= diff_ba >> 1;
			end
		end
		if (cmd.gcd_fold) begin
			a_q <= a_q | b_q;
		end
		if (cmd.shl_step) begin
			a_q <= a_q << 1;
			k_q <= k_q - 1'b1;
		end
		if (cmd.div_init) begin
			qn_q  <= nmag_q;
			qd_q  <= dmag_q;
			rn_q  <= '0;
			rd_q  <= '0;
			cnt_q <= frac_pkg::CNT_WIDTH'(W - 1);
		end
		if (cmd.div_step) begin
			rn_q  <= n_ge ? rn_sub[W-1:0] : rn_sh[W-1:0];
			rd_q  <= d_ge ? rd_sub[W-1:0] : rd_sh[W-1:0];
			qn_q  <= {qn_q[W-2:0], n_ge};
			qd_q  <= {qd_q[W-2:0], d_ge};
			cnt_q <= cnt_q - 1'b1;
		end
		if (cmd.out_load) begin
			reduced_numerator   <= nneg_q ? (~out_n + 1'b1) : out_n;
			reduced_denominator <= dneg_q ? (~out_d + 1'b1) : out_d;
			zero_denominator    <= err_q;
			if (err_q) begin
				divisor <= '0;
			end else if (a_q[W-1]) begin
				divisor <= '1;
			end else begin
				divisor <= a_q[W-2:0];
			end
		end
	end

endmodule

FILE: src/fraction_reducer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fraction_reducer_unit
// Reduces one signed fraction per item by the gcd of the magnitudes.
// ----------------------------------------------------------------------------
// One item is worked on at a time. It takes G binary gcd steps (one shift
// or subtract per cycle, at most about 2W, where W is the data width, 32),
// then restores the K common factors of two by a one-bit shift per cycle.
// The two quotients come from a pair of restoring dividers, one bit per
// cycle, sharing the divisor. A zero denominator skips the gcd, shift and
// division steps.
// A finished result waits in the output register while the next item is taken.
module fraction_reducer_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// numerator, denominator
	input  logic [frac_pkg::S_TDATA_WIDTH-1:0] s_tdata,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// reduced_numerator, reduced_denominator, divisor, zero pad
	output logic [frac_pkg::M_TDATA_WIDTH-1:0] m_tdata,
	// zero_denominator
	output logic                               m_tuser
);

	localparam int W = frac_pkg::DATA_WIDTH;

	frac_pkg::cmd_t                    cmd;
	frac_pkg::sts_t                    sts;
	logic signed [W-1:0]               red_num, red_den;
	logic [frac_pkg::DIV_WIDTH-1:0]    div_val;

	frac_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	frac_dp u_dp (
		.clk                 (clk),
		.cmd                 (cmd),
		.sts                 (sts),
		.numerator           (s_tdata[W-1:0]),
		.denominator         (s_tdata[2*W-1:W]),
		.reduced_numerator   (red_num),
		.reduced_denominator (red_den),
		.divisor             (div_val),
		.zero_denominator    (m_tuser)
	);

	generate
		if (frac_pkg::M_PAD_WIDTH > 0) begin : g_pad
			assign m_tdata = {{frac_pkg::M_PAD_WIDTH{1'b0}}, div_val, red_den, red_num};
		end else begin : g_nopad
			assign m_tdata = {div_val, red_den, red_num};
		end
	endgenerate

endmodule

FILE: src/frac_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frac_checker
// Port-level checks on the fraction reducer results.
// ----------------------------------------------------------------------------
module frac_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	input  logic                               s_tready,
	input  logic                               m_tvalid,
	input  logic                               m_tready,
	input  logic [frac_pkg::M_TDATA_WIDTH-1:0] m_tdata,
	input  logic                               m_tuser
);

	localparam int W = frac_pkg::DATA_WIDTH;

	logic [W-1:0]                   chk_num, chk_den;
	logic [frac_pkg::DIV_WIDTH-1:0] chk_div;

	assign chk_num = m_tdata[W-1:0];
	assign chk_den = m_tdata[2*W-1:W];
	assign chk_div = m_tdata[2*W+frac_pkg::DIV_WIDTH-1:2*W];

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken again while an item is in flight");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result item dropped while stalled");

	a_err_div: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> (chk_div == '0) && (chk_den == '0))
		else $error("error item with nonzero divisor or denominator");

	a_ok_div: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> (chk_div != '0) && (chk_den != '0))
		else $error("reduced item with zero divisor or denominator");

	a_zero_num: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser && (chk_num == '0) |->
			(chk_den == W'(1)) || (chk_den == '1))
		else $error("zero numerator not reduced to plus or minus one");

endmodule

bind fraction_reducer_unit frac_checker u_frac_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
